>>> design/sts_pkg.sv
// Package for the scene table store: command and status codes, field widths
// and the default table depth. No dependencies.
package sts_pkg;

  localparam int unsigned TableEntriesDefault = 16;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned IdW     = 16;
  localparam int unsigned LightW  = 8;
  localparam int unsigned IntenW  = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned EntryW  = IdW + LightW + IntenW;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 16;

  localparam logic [CmdW-1:0] CmdConfigure = 2'd0;
  localparam logic [CmdW-1:0] CmdRecall    = 2'd1;
  localparam logic [CmdW-1:0] CmdDelete    = 2'd2;

  localparam logic [StatusW-1:0] StatusDone     = 2'd0;
  localparam logic [StatusW-1:0] StatusInserted = 2'd1;
  localparam logic [StatusW-1:0] StatusFull     = 2'd2;
  localparam logic [StatusW-1:0] StatusNotFound = 2'd3;

endpackage

>>> design/scene_table_store_core.sv
// Scene table store: a table of lighting scenes searched one entry at a time.
// Depends on sts_pkg for codes, widths and the default depth.
//
// Steps per item: one table read per entry, each entry compared in the cycle after
// its read, then the scan is left, and the decide step writes back and registers the
// result. The core takes no new item before the last one is decided: the next item
// is taken in the idle cycle after the result, and a result still held delays decide.
// Reset: rst_ni clears all per-entry valid bits at once, so every entry reads as free.
module scene_table_store_core #(
  parameter int unsigned TABLE_ENTRIES = sts_pkg::TableEntriesDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Command item. tdata from bit 0: cmd[1:0], scene_id[17:2], light_id[25:18],
  // intensity[33:26], zero fill [39:34].
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [sts_pkg::InDataW-1:0]  s_axis_tdata,
  // Result item. tdata from bit 0: status[1:0], slot[5:2],
  // recalled_intensity[13:6], recall_valid[14], zero fill [15].
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [sts_pkg::OutDataW-1:0] m_axis_tdata
);
  import sts_pkg::*;

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_e;

  state_e state_q;

  // Captured command.
  logic [CmdW-1:0]   cmd_q;
  logic [IdW-1:0]    id_q;
  logic [LightW-1:0] light_q;
  logic [IntenW-1:0] inten_q;

  // Scan sequencer: issue counter and one read in flight.
  logic [IdxW-1:0] cnt_q;
  logic            issue_q;
  logic            pend_q;
  logic [IdxW-1:0] pend_idx_q;

  // Search results: lowest match and lowest free entry.
  logic              hit_q;
  logic [IdxW-1:0]   hit_idx_q;
  logic [IntenW-1:0] hit_int_q;
  logic [IdW-1:0]    hit_id_q;
  logic              free_q;
  logic [IdxW-1:0]   free_idx_q;

  // Table memory with registered read and per-entry valid bits.
  logic [EntryW-1:0] mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] vld_q;
  logic [EntryW-1:0] rdata_q;
  logic              rvld_q;
  logic              rd_en;

  logic              mem_we;
  logic [IdxW-1:0]   wr_addr;
  logic [EntryW-1:0] wr_data;

  // Result register.
  logic               out_valid_q;
  logic [StatusW-1:0] out_status_q;
  logic [SlotW-1:0]   out_slot_q;
  logic [IntenW-1:0]  out_int_q;
  logic               out_rv_q;

  logic [StatusW-1:0] res_status;
  logic [SlotW-1:0]   res_slot;
  logic [IntenW-1:0]  res_int;
  logic               res_rv;

  logic [EntryW-1:0] ent;
  logic              ent_match;
  logic              ent_free;
  logic              in_fire;
  logic              out_free;
  logic              commit;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign commit        = (state_q == S_DECIDE) && out_free;
  assign rd_en         = (state_q == S_SCAN) && issue_q;

  // An entry whose valid bit is clear has never been written since reset: free.
  assign ent       = rvld_q ? rdata_q : '0;
  assign ent_match = (ent[IdW-1:0] == id_q);
  assign ent_free  = (ent[IdW-1:0] == '0);

  // Decision on the scan result: status, slot and write-back.
  always_comb begin
    res_status = StatusNotFound;
    res_slot   = '0;
    res_int    = '0;
    res_rv     = 1'b0;
    mem_we     = 1'b0;
    wr_addr    = hit_idx_q;
    wr_data    = {inten_q, light_q, id_q};
    unique case (cmd_q)
      CmdConfigure: begin
        if (hit_q) begin
          res_status = StatusDone;
          res_slot   = SlotW'(hit_idx_q);
          mem_we     = commit;
        end else if (free_q) begin
          res_status = StatusInserted;
          res_slot   = SlotW'(free_idx_q);
          wr_addr    = free_idx_q;
          mem_we     = commit;
        end else begin
          res_status = StatusFull;
        end
      end
      CmdRecall: begin
        // A match on a free entry (id zero) is not a scene.
        if (hit_q && (hit_id_q != '0)) begin
          res_status = StatusDone;
          res_slot   = SlotW'(hit_idx_q);
          res_int    = hit_int_q;
          res_rv     = 1'b1;
        end
      end
      CmdDelete: begin
        if (hit_q) begin
          res_status = StatusDone;
          res_slot   = SlotW'(hit_idx_q);
          wr_data    = '0;
          mem_we     = commit;
        end
      end
      default: begin
        res_status = StatusNotFound;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[cnt_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvld_q <= vld_q[cnt_q];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q   <= s_axis_tdata[1:0];
      id_q    <= s_axis_tdata[17:2];
      light_q <= s_axis_tdata[25:18];
      inten_q <= s_axis_tdata[33:26];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      issue_q      <= 1'b0;
      pend_q       <= 1'b0;
      pend_idx_q   <= '0;
      hit_q        <= 1'b0;
      hit_idx_q    <= '0;
      hit_int_q    <= '0;
      hit_id_q     <= '0;
      free_q       <= 1'b0;
      free_idx_q   <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_slot_q   <= '0;
      out_int_q    <= '0;
      out_rv_q     <= 1'b0;
    end else begin
      // A result taken in the cycle of a new decision is replaced, not cleared.
      if (out_valid_q && m_axis_tready && !commit) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            state_q <= S_SCAN;
            cnt_q   <= '0;
            issue_q <= 1'b1;
            pend_q  <= 1'b0;
            hit_q   <= 1'b0;
            free_q  <= 1'b0;
          end
        end
        S_SCAN: begin
          // Issue one read per cycle; compare the entry read in the cycle before.
          pend_q     <= issue_q;
          pend_idx_q <= cnt_q;
          if (issue_q) begin
            if (cnt_q == LastIdx) begin
              issue_q <= 1'b0;
            end else begin
              cnt_q <= cnt_q + IdxW'(1);
            end
          end
          if (pend_q) begin
            if (ent_match && !hit_q) begin
              hit_q     <= 1'b1;
              hit_idx_q <= pend_idx_q;
              hit_int_q <= ent[EntryW-1 -: IntenW];
              hit_id_q  <= ent[IdW-1:0];
            end
            if (ent_free && !free_q) begin
              free_q     <= 1'b1;
              free_idx_q <= pend_idx_q;
            end
          end
          if (!issue_q && !pend_q) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status;
            out_slot_q   <= res_slot;
            out_int_q    <= res_int;
            out_rv_q     <= res_rv;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_rv_q, out_int_q, out_slot_q, out_status_q};

  // A successful recall always reports status done.
  a_recall_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_rv_q) |-> (out_status_q == StatusDone))
    else $error("recall_valid with status other than done");

  // The table is written only when a decision is committed.
  a_write_in_decide : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_DECIDE))
    else $error("table write outside the decide step");

  // A full table is reported only when the scan found neither match nor free entry.
  a_full_no_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && (res_status == StatusFull)) |-> (!hit_q && !free_q))
    else $error("table full reported with a usable entry");

  // An accepted item starts a scan in the next cycle.
  a_fire_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> ((state_q == S_SCAN) && issue_q && (cnt_q == '0)))
    else $error("scan did not start after an accepted item");

  // An in-flight read always carries an index inside the table.
  a_pend_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (pend_idx_q <= LastIdx))
    else $error("scan index beyond the table");

endmodule
